// ===== src/psrb_pkg.sv =====
// shared types, status codes and state encodings for the per-sender reorder buffer
package psrb_pkg;

  // value of the senders-in-use register after reset
  localparam logic [4:0] SENDERS_RESET = 5'd16;

  // result status codes
  localparam logic [2:0] STAT_DELIVERED  = 3'd0;
  localparam logic [2:0] STAT_HELD       = 3'd1;
  localparam logic [2:0] STAT_STALE      = 3'd2;
  localparam logic [2:0] STAT_BEYOND     = 3'd3;
  localparam logic [2:0] STAT_BAD_SENDER = 3'd4;

  // one incoming message
  typedef struct packed {
    logic [4:0]  sender;
    logic [31:0] seq_id;
    logic [31:0] payload;
  } in_item_t;

  // one result transfer
  typedef struct packed {
    logic [4:0]  out_sender;
    logic [31:0] out_seq_id;
    logic [31:0] out_payload;
    logic        delivered;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DRAIN
  } fsm_state_t;

  // classification of a message against its sender's state
  typedef enum logic [2:0] {
    V_BAD,
    V_STALE,
    V_BEYOND,
    V_DUP,
    V_HOLD,
    V_DELIVER
  } verdict_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic eval;
    logic drain;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eval_more;
    logic drain_more;
  } dp_status_t;

endpackage

// ===== src/psrb_ctrl.sv =====
// sequencer for the reorder buffer: accept, evaluate, drain
module psrb_ctrl import psrb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  fsm_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = status.eval_more ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        state_next = status.drain_more ? S_DRAIN : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/psrb_datapath.sv =====
// per-sender state memory, held payload memory, classification and result register
module psrb_datapath import psrb_pkg::*; #(
  parameter int NUM_SENDERS  = 16,
  parameter int WINDOW       = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  dp_cmd_t    cmd,
  input  in_item_t   item,
  output dp_status_t status,
  output logic       result_valid,
  output result_t    result
);

  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int IDX_W      = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int PA_W       = $clog2(NUM_SENDERS * WINDOW);
  localparam int STORE_BITS = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int REC_W      = 32 + SLOT_W + WINDOW;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [SLOT_W:0]   WIN_SUM   = (SLOT_W + 1)'(WINDOW);
  localparam logic [31:0]       WIN_SEQ   = 32'(WINDOW);
  localparam logic [CNT_W-1:0]  WIN_CNT   = CNT_W'(WINDOW);
  localparam logic [PA_W-1:0]   WIN_PA    = PA_W'(WINDOW);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  logic [4:0]             siu;
  logic [4:0]             snd_m1;
  logic                   bad_in;
  logic [IDX_W-1:0]       idx_in;
  in_item_t               item_r;
  logic                   bad_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   touched_r;
  logic [NUM_SENDERS-1:0] touched;
  logic [REC_W-1:0]       smem [NUM_SENDERS];
  logic [REC_W-1:0]       rec_r;
  logic                   sm_we;
  logic [REC_W-1:0]       sm_wdata;
  logic [31:0]            ne_e;
  logic [SLOT_W-1:0]      slot_e;
  logic [WINDOW-1:0]      hv_e;
  logic [31:0]            d;
  logic [SLOT_W:0]        hsum;
  logic [SLOT_W-1:0]      hslot;
  logic [SLOT_W-1:0]      nslot_e;
  logic [WINDOW-1:0]      hv_h;
  verdict_t               verdict;
  logic [31:0]            ne_w;
  logic [SLOT_W-1:0]      slot_w;
  logic [WINDOW-1:0]      hv_w;
  logic [CNT_W-1:0]       cnt;
  logic [WINDOW-1:0]      hv_d;
  logic [SLOT_W-1:0]      nslot_d;
  logic [CNT_W-1:0]       cnt_inc;
  logic [STORE_BITS-1:0]  pmem [NUM_SENDERS * WINDOW];
  logic [STORE_BITS-1:0]  pm_rdata;
  logic                   pm_we;
  logic                   pm_re;
  logic [PA_W-1:0]        pm_base;
  logic [PA_W-1:0]        pm_waddr;
  logic [PA_W-1:0]        pm_raddr;
  result_t                res_eval;
  result_t                res_drain;

  // senders-in-use register
  always_ff @(posedge clk) begin
    if (rst) begin
      siu <= SENDERS_RESET;
    end else if (cfg_we) begin
      siu <= cfg_wdata;
    end
  end

  // sender check and index at the input transfer
  assign snd_m1 = item.sender - 5'd1;
  assign bad_in = (item.sender == 5'd0) || (item.sender > siu) ||
                  (int'(item.sender) > NUM_SENDERS);
  assign idx_in = bad_in ? '0 : IDX_W'(snd_m1);

  // capture the message
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r    <= item;
      bad_r     <= bad_in;
      idx_r     <= idx_in;
      touched_r <= touched[idx_in];
    end
  end

  // sender state memory: {next expected, its slot, held valid bits}
  always_ff @(posedge clk) begin
    if (sm_we) smem[idx_r] <= sm_wdata;
    if (cmd.accept) rec_r <= smem[idx_in];
  end

  // a sender not yet written reads as its reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
    end else if (sm_we) begin
      touched[idx_r] <= 1'b1;
    end
  end

  assign ne_e   = touched_r ? rec_r[REC_W-1 -: 32] : 32'd1;
  assign slot_e = touched_r ? rec_r[WINDOW +: SLOT_W] : SLOT_W'(1);
  assign hv_e   = touched_r ? rec_r[WINDOW-1:0] : '0;

  // distance and slot of the incoming message
  assign d       = item_r.seq_id - ne_e;
  assign hsum    = {1'b0, slot_e} + {1'b0, d[SLOT_W-1:0]};
  assign hslot   = (hsum >= WIN_SUM) ? SLOT_W'(hsum - WIN_SUM) : hsum[SLOT_W-1:0];
  assign nslot_e = slot_inc(slot_e);

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      hv_h[i] = hv_e[i] || (SLOT_W'(i) == hslot);
    end
  end

  // classify
  always_comb begin
    priority if (bad_r)            verdict = V_BAD;
    else if (d[31])                verdict = V_STALE;
    else if (d >= WIN_SEQ)         verdict = V_BEYOND;
    else if (d != 32'd0) begin
      if (hv_e[hslot])             verdict = V_DUP;
      else                         verdict = V_HOLD;
    end
    else                           verdict = V_DELIVER;
  end

  // drain step: release the slot, look at the one after it
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      hv_d[i] = hv_w[i] && (SLOT_W'(i) != slot_w);
    end
  end
  assign nslot_d = slot_inc(slot_w);
  assign cnt_inc = cnt + 1'b1;

  assign status.eval_more  = (verdict == V_DELIVER) && hv_e[nslot_e];
  assign status.drain_more = hv_d[nslot_d] && (cnt_inc < WIN_CNT);

  // working copy of the sender state during a drain
  always_ff @(posedge clk) begin
    if (cmd.eval && (verdict == V_DELIVER)) begin
      ne_w   <= item_r.seq_id + 32'd1;
      slot_w <= nslot_e;
      hv_w   <= hv_e;
      cnt    <= CNT_W'(1);
    end else if (cmd.drain) begin
      ne_w   <= ne_w + 32'd1;
      slot_w <= nslot_d;
      hv_w   <= hv_d;
      cnt    <= cnt_inc;
    end
  end

  // state write-back
  always_comb begin
    sm_we    = 1'b0;
    sm_wdata = {ne_e, slot_e, hv_h};
    priority if (cmd.eval) begin
      if (verdict == V_HOLD) begin
        sm_we = 1'b1;
      end else if (verdict == V_DELIVER) begin
        sm_we    = !status.eval_more;
        sm_wdata = {item_r.seq_id + 32'd1, nslot_e, hv_e};
      end
    end else if (cmd.drain) begin
      sm_we    = !status.drain_more;
      sm_wdata = {ne_w + 32'd1, nslot_d, hv_d};
    end else begin
      sm_we = 1'b0;
    end
  end

  // held payload memory, addressed by sender and slot
  assign pm_base  = PA_W'(idx_r) * WIN_PA;
  assign pm_we    = cmd.eval && (verdict == V_HOLD);
  assign pm_waddr = pm_base + PA_W'(hslot);
  assign pm_re    = (cmd.eval && status.eval_more) || (cmd.drain && status.drain_more);
  assign pm_raddr = pm_base + PA_W'(cmd.drain ? nslot_d : nslot_e);

  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_waddr] <= item_r.payload[STORE_BITS-1:0];
    if (pm_re) pm_rdata <= pmem[pm_raddr];
  end

  // result of the evaluation cycle
  always_comb begin
    res_eval.out_sender  = item_r.sender;
    res_eval.out_seq_id  = item_r.seq_id;
    res_eval.delivered   = (verdict == V_DELIVER);
    res_eval.out_payload = res_eval.delivered ? 32'(item_r.payload[STORE_BITS-1:0]) : 32'd0;
    res_eval.last        = !status.eval_more;
    unique case (verdict)
      V_BAD:     res_eval.status = STAT_BAD_SENDER;
      V_STALE:   res_eval.status = STAT_STALE;
      V_DUP:     res_eval.status = STAT_STALE;
      V_BEYOND:  res_eval.status = STAT_BEYOND;
      V_HOLD:    res_eval.status = STAT_HELD;
      V_DELIVER: res_eval.status = STAT_DELIVERED;
      default:   res_eval.status = STAT_BAD_SENDER;
    endcase
  end

  // result of a drain cycle
  always_comb begin
    res_drain.out_sender  = item_r.sender;
    res_drain.out_seq_id  = ne_w;
    res_drain.out_payload = 32'(pm_rdata);
    res_drain.delivered   = 1'b1;
    res_drain.status      = STAT_DELIVERED;
    res_drain.last        = !status.drain_more;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.eval || cmd.drain;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      result <= res_eval;
    end else if (cmd.drain) begin
      result <= res_drain;
    end
  end

endmodule

// ===== src/per_sender_reorder_buffer.sv =====
// top level of the per-sender reorder buffer
// Usage:
//   Input: drive item and raise start; the message is taken at a rising edge
//   where start is high and busy is low. busy stays high until the last result
//   of that message has been presented.
//   Output: each result shows on result for exactly one cycle with result_valid
//   high; result.last marks the final result of a message. The receiver cannot
//   stall, so results are never held back.
//   Config: cfg_we writes cfg_wdata to senders_in_use; valid ids 1..min(value,
//   NUM_SENDERS); write it only while busy is low and no result is still pending.
// Timing:
//   the message is registered at the input transfer, then evaluated, and the
//   first result is registered from that evaluation. A delivery that releases
//   k held messages gives 1 + k results on consecutive cycles, one per cycle,
//   since each drained entry is one read of the held payload memory.
//   The sender state memory is read once per message and written back at most
//   once (never for bad-sender, stale, duplicate or out-of-window messages).
// Reset:
//   senders_in_use returns to 16, every sender expects sequence number 1 and
//   holds nothing. A per-sender touched bit stands in for the reset of the
//   state memory, so there is no clearing pass: the block is ready right away.
module per_sender_reorder_buffer import psrb_pkg::*; #(
  parameter int NUM_SENDERS  = 16,
  parameter int WINDOW       = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       start,
  input  in_item_t   item,
  output logic       busy,
  output logic       result_valid,
  output result_t    result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  psrb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // state, memories and result register
  psrb_datapath #(
    .NUM_SENDERS  (NUM_SENDERS),
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .item         (item),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== src/psrb_checker.sv =====
// port-level checks for the reorder buffer and their bind
module psrb_checker import psrb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic [4:0] cfg_wdata,
  input logic       start,
  input in_item_t   item,
  input logic       busy,
  input logic       result_valid,
  input result_t    result
);

  // idle right after reset
  a_idle_after_reset: assert property (@(posedge clk) $past(rst) |-> !busy)
    else $error("busy high right after reset");

  // an input transfer starts work
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  // a result that is not last is followed by another one
  a_drain_continuous: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |=> result_valid)
    else $error("result sequence broken before last");

  // busy drops together with the last result
  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (result_valid && result.last))
    else $error("busy dropped without a last result");

  // delivered flag agrees with the status code
  a_delivered_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.delivered == (result.status == STAT_DELIVERED)))
    else $error("delivered flag and status disagree");

endmodule

bind per_sender_reorder_buffer psrb_checker u_psrb_checker (.*);
